[hw/rtl/smerge_pkg.sv]
`default_nettype none

package smerge_pkg;

    // fixed field widths of the stream and config ports
    localparam int CHANNEL_W = 3;
    localparam int COUNT_W   = 4;
    localparam int KIND_W    = 2;
    localparam int TDATA_W   = 64;
    localparam int TUSER_W   = CHANNEL_W + KIND_W;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_MERGED  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_FINISH  = 2'd2
    } result_kind_t;

endpackage

`default_nettype wire

[hw/rtl/smerge_min_tree.sv]
`default_nettype none

module smerge_min_tree #(
    parameter int NUM_CHANNELS = 8,
    parameter int TIME_BITS    = 64
) (
    input  wire logic [NUM_CHANNELS-1:0]         head_valid,
    input  wire logic [TIME_BITS-1:0]            head_time [NUM_CHANNELS],
    output logic                                 any_valid,
    output logic [$clog2(NUM_CHANNELS)-1:0]      best_idx,
    output logic [TIME_BITS-1:0]                 best_time
);

    localparam int IDX_W = $clog2(NUM_CHANNELS);
    localparam int LVLS  = IDX_W;
    localparam int LEAVES = 1 << LVLS;

    logic [LEAVES-1:0]    v_lvl [LVLS+1];
    logic [TIME_BITS-1:0] t_lvl [LVLS+1][LEAVES];
    logic [IDX_W-1:0]     i_lvl [LVLS+1][LEAVES];

    // pairwise tree, left (lower channel) wins ties
    always_comb begin
        for (int l = 0; l <= LVLS; l++) begin
            v_lvl[l] = '0;
            for (int j = 0; j < LEAVES; j++) begin
                t_lvl[l][j] = '0;
                i_lvl[l][j] = '0;
            end
        end
        for (int j = 0; j < NUM_CHANNELS; j++) begin
            v_lvl[0][j] = head_valid[j];
            t_lvl[0][j] = head_time[j];
            i_lvl[0][j] = IDX_W'(j);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < LEAVES / 2; j++) begin
                if (j < (LEAVES >> (l + 1))) begin
                    v_lvl[l+1][j] = v_lvl[l][2*j] | v_lvl[l][2*j+1];
                    if (v_lvl[l][2*j+1] &&
                        (!v_lvl[l][2*j] || (t_lvl[l][2*j+1] < t_lvl[l][2*j]))) begin
                        t_lvl[l+1][j] = t_lvl[l][2*j+1];
                        i_lvl[l+1][j] = i_lvl[l][2*j+1];
                    end else begin
                        t_lvl[l+1][j] = t_lvl[l][2*j];
                        i_lvl[l+1][j] = i_lvl[l][2*j];
                    end
                end
            end
        end
    end

    assign any_valid = v_lvl[LVLS][0];
    assign best_idx  = i_lvl[LVLS][0];
    assign best_time = t_lvl[LVLS][0];

endmodule

`default_nettype wire

[hw/rtl/sorted_stream_merge.sv]
`default_nettype none

// k-way merge of ascending timestamp streams. Each input beat carries one
// channel's next timestamp (tdata) or, with tlast high, that channel's end
// mark; tuser selects the channel. One head is held per channel. While every
// live channel in use holds a head, the smallest head leaves on the output,
// ties to the lowest channel. Once every channel in use has ended, the heads
// left drain in order and a finish beat follows, which clears all end marks.
// Timestamps for a channel that already holds a head, and items for a channel
// that has ended or that is at or above the configured count, come back as a
// dropped beat with state untouched. The output tuser carries the result kind
// and source channel, and tlast marks the final result beat caused by one
// input beat. Rate: beats that cause zero or one result beat do not hold the
// input side and stream in every cycle while m_tready does not stall the
// output; a beat causing k results holds the input side until all are out,
// one result per cycle while m_tready is high, limited by the output register.
// A beat passes the input register, then the result register. The critical
// path is the head update mux plus a log2(NUM_CHANNELS)-level tree of
// TIME_BITS-wide compares. channel_count may only be written while idle; 0
// acts as 1 and values above NUM_CHANNELS act as NUM_CHANNELS.
module sorted_stream_merge
    import smerge_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int TIME_BITS    = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // config: channel_count
    input  wire logic                 cfg_wr_en,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data,

    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // [63:0] timestamp
    input  wire logic [CHANNEL_W-1:0] s_tuser,   // [2:0] channel
    input  wire logic                 s_tlast,   // end_of_stream

    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata,   // [63:0] merged_time
    output logic [TUSER_W-1:0]        m_tuser,   // [1:0] result_kind, [4:2] source_channel
    output logic                      m_tlast    // last
);

    localparam int IDX_W = $clog2(NUM_CHANNELS);
    localparam int CMP_W = 8;

    // channel state
    logic [TIME_BITS-1:0]    head_time_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] head_valid_reg, head_valid_next;
    logic [NUM_CHANNELS-1:0] done_reg, done_next;
    logic [COUNT_W-1:0]      count_reg;

    // input register
    logic                    in_valid_reg, in_valid_next;
    logic [CHANNEL_W-1:0]    in_ch_reg;
    logic [TIME_BITS-1:0]    in_ts_reg;
    logic                    in_eos_reg;

    // more results owed for the beat already taken
    logic                    busy_reg, busy_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [TIME_BITS-1:0]    m_time_reg, m_time_next;
    logic [CHANNEL_W-1:0]    m_src_reg, m_src_next;
    result_kind_t            m_kind_reg, m_kind_next;
    logic                    m_last_reg, m_last_next;

    logic [CMP_W-1:0]        eff_count;
    logic [NUM_CHANNELS-1:0] live;
    logic [IDX_W-1:0]        in_idx;
    logic                    out_free;
    logic                    take_in;
    logic                    bad_ch;
    logic                    drop;
    logic                    accept_item;
    logic                    eval;

    logic [NUM_CHANNELS-1:0] view_valid;
    logic [NUM_CHANNELS-1:0] view_done;
    logic [TIME_BITS-1:0]    view_time [NUM_CHANNELS];

    logic                    tree_any;
    logic [IDX_W-1:0]        best_idx;
    logic [TIME_BITS-1:0]    best_time;
    logic                    ready_all;
    logic                    all_done;
    logic                    emit_head;
    logic                    emit_finish;
    logic [NUM_CHANNELS-1:0] emit_mask;

    // effective channel count, clamped to 1 .. NUM_CHANNELS
    always_comb begin
        if (count_reg == '0) begin
            eff_count = CMP_W'(1);
        end else if (int'(count_reg) > NUM_CHANNELS) begin
            eff_count = CMP_W'(NUM_CHANNELS);
        end else begin
            eff_count = CMP_W'(count_reg);
        end
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            live[i] = CMP_W'(i) < eff_count;
        end
    end

    // handshake: input register empties when its beat is processed
    assign out_free    = !m_valid_reg || m_tready;
    assign take_in     = !busy_reg && in_valid_reg && out_free;
    assign s_tready    = !in_valid_reg || take_in;

    assign in_idx      = IDX_W'(in_ch_reg);
    assign bad_ch      = CMP_W'(in_ch_reg) >= eff_count;
    assign drop        = take_in &&
                         (bad_ch || done_reg[in_idx] || (!in_eos_reg && head_valid_reg[in_idx]));
    assign accept_item = take_in && !drop;
    assign eval        = (busy_reg && out_free) || accept_item;

    // state as it stands once the accepted beat is folded in
    always_comb begin
        view_valid = head_valid_reg;
        view_done  = done_reg;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            view_time[i] = head_time_reg[i];
        end
        if (accept_item) begin
            if (in_eos_reg) begin
                view_done[in_idx] = 1'b1;
            end else begin
                view_valid[in_idx] = 1'b1;
                view_time[in_idx]  = in_ts_reg;
            end
        end
    end

    smerge_min_tree #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    ) u_min_tree (
        .head_valid (view_valid & live),
        .head_time  (view_time),
        .any_valid  (tree_any),
        .best_idx   (best_idx),
        .best_time  (best_time)
    );

    // every live channel must hold a head or have ended before a head leaves
    assign ready_all   = &(~live | view_valid | view_done);
    assign all_done    = &(~live | (view_done & ~view_valid));
    assign emit_head   = eval && ready_all && tree_any;
    assign emit_finish = eval && !emit_head && all_done;
    assign emit_mask   = emit_head ? (NUM_CHANNELS'(1) << best_idx) : '0;

    always_comb begin
        in_valid_next   = in_valid_reg;
        busy_next       = busy_reg;
        head_valid_next = head_valid_reg;
        done_next       = done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_time_next     = m_time_reg;
        m_src_next      = m_src_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (take_in) begin
            in_valid_next = 1'b0;
        end

        if (eval) begin
            head_valid_next = view_valid & ~emit_mask;
            done_next       = emit_finish ? '0 : view_done;
            // an ended channel giving up its head always leaves more to emit
            busy_next       = emit_head && view_done[best_idx];
        end

        priority if (drop) begin
            m_valid_next = 1'b1;
            m_kind_next  = KIND_DROPPED;
            m_time_next  = '0;
            m_src_next   = in_ch_reg;
            m_last_next  = 1'b1;
        end else if (emit_head) begin
            m_valid_next = 1'b1;
            m_kind_next  = KIND_MERGED;
            m_time_next  = best_time;
            m_src_next   = CHANNEL_W'(best_idx);
            m_last_next  = !view_done[best_idx];
        end else if (emit_finish) begin
            m_valid_next = 1'b1;
            m_kind_next  = KIND_FINISH;
            m_time_next  = '0;
            m_src_next   = '0;
            m_last_next  = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
            done_reg       <= '0;
            count_reg      <= COUNT_RESET;
            in_valid_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            done_reg       <= done_next;
            in_valid_reg   <= in_valid_next;
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tuser;
            in_ts_reg  <= s_tdata[TIME_BITS-1:0];
            in_eos_reg <= s_tlast;
        end
        if (accept_item && !in_eos_reg) begin
            head_time_reg[in_idx] <= in_ts_reg;
        end
        m_time_reg <= m_time_next;
        m_src_reg  <= m_src_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_time_reg);
    assign m_tuser  = {m_src_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

    // owing more results means a non-final beat is on the output
    a_busy_has_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (m_valid_reg && !m_last_reg))
        else $error("busy without a pending non-final result beat");

    a_finish_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_FINISH) |-> (m_last_reg && m_time_reg == '0))
        else $error("finish beat malformed");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_finish |=> (done_reg == '0))
        else $error("end marks not cleared after finish");

    a_drop_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        drop |=> (head_valid_reg == $past(head_valid_reg) && done_reg == $past(done_reg)))
        else $error("dropped beat changed channel state");

endmodule

`default_nettype wire
